// ===== hw/rtl/akd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package akd_pkg;

    // Number of button channels that hold state.
    localparam int CHANNELS = 2;
    localparam int CH_W = 1;
    localparam int CH_ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // ADC scaling: millivolts = raw * MV_FULL_SCALE / ADC_FULL_SCALE.
    localparam int SAMPLE_W = 12;
    localparam int MV_W = 12;
    localparam int PROD_W = 24;
    localparam int MV_FULL_SCALE = 3300;
    localparam int ADC_FULL_SCALE = 4095;

    localparam int TIME_W = 32;
    localparam int LONG_W = 16;
    localparam logic [TIME_W-1:0] REPEAT_MS = 32'd40;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values.
    localparam logic [MV_W-1:0] RST_RELEASE_MV = 12'd2800;
    localparam logic [MV_W-1:0] RST_SET_LO_MV = 12'd100;
    localparam logic [MV_W-1:0] RST_SET_HI_MV = 12'd700;
    localparam logic [MV_W-1:0] RST_UP_LO_MV = 12'd900;
    localparam logic [MV_W-1:0] RST_UP_HI_MV = 12'd1500;
    localparam logic [MV_W-1:0] RST_DOWN_LO_MV = 12'd1700;
    localparam logic [MV_W-1:0] RST_DOWN_HI_MV = 12'd2300;
    localparam logic [LONG_W-1:0] RST_LONG_PRESS_MS = 16'd5000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RELEASE_MV = 3'd0,
        CFG_SET_LO_MV = 3'd1,
        CFG_SET_HI_MV = 3'd2,
        CFG_UP_LO_MV = 3'd3,
        CFG_UP_HI_MV = 3'd4,
        CFG_DOWN_LO_MV = 3'd5,
        CFG_DOWN_HI_MV = 3'd6,
        CFG_LONG_PRESS_MS = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_SET_PUSH = 3'd0,
        EV_LONG_SET = 3'd1,
        EV_SET_REL = 3'd2,
        EV_UP_PUSH = 3'd3,
        EV_UP_REL = 3'd4,
        EV_DOWN_PUSH = 3'd5,
        EV_DOWN_REL = 3'd6,
        EV_NONE = 3'd7
    } event_code_t;

    typedef struct packed {
        logic [MV_W-1:0] release_mv;
        logic [MV_W-1:0] set_lo_mv;
        logic [MV_W-1:0] set_hi_mv;
        logic [MV_W-1:0] up_lo_mv;
        logic [MV_W-1:0] up_hi_mv;
        logic [MV_W-1:0] down_lo_mv;
        logic [MV_W-1:0] down_hi_mv;
        logic [LONG_W-1:0] long_press_ms;
    } cfg_t;

    // Per-channel state as kept in the state memory.
    typedef struct packed {
        logic pressed;
        logic [TIME_W-1:0] start_ms;
        event_code_t last_event;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

    localparam chan_state_t STATE_RESET = '{
        pressed: 1'b0,
        start_ms: '0,
        last_event: EV_NONE
    };

    // Divide a scaled sample by ADC_FULL_SCALE (4096 - 1). The estimate
    // (p + p/4096) / 4096 is low by at most one; one compare fixes it.
    function automatic logic [MV_W-1:0] mv_from_product(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] sum;
        logic [MV_W-1:0] q;
        logic [PROD_W:0] rem;
        sum = {1'b0, p} + {13'b0, p[PROD_W-1:12]};
        q = sum[PROD_W-1:12];
        rem = {1'b0, p} + {13'b0, q} - {1'b0, q, 12'b0};
        if (rem >= (PROD_W + 1)'(ADC_FULL_SCALE)) begin
            q = q + 1'b1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/akd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module akd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [ADDR_W-1:0]      waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [ADDR_W-1:0]      raddr,
    output      logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port; a read at the written
    // address returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/akd_decide.sv =====
`timescale 1ns / 1ps
`default_nettype none

module akd_decide
    import akd_pkg::*;
(
    input  wire logic [CH_W-1:0]   channel,
    input  wire logic [MV_W-1:0]   first_mv,
    input  wire logic [MV_W-1:0]   confirm_mv,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire cfg_t              cfg,
    input  wire chan_state_t       state,
    output      event_code_t       event_code,
    output      chan_state_t       state_next
);

    logic              is_set;
    logic              is_up;
    logic              is_down;
    logic              up_code;
    logic [TIME_W-1:0] elapsed;
    event_code_t       ev;

    // Window classification of the confirm reading; set wins, then up.
    assign is_set = (confirm_mv > cfg.set_lo_mv) && (confirm_mv < cfg.set_hi_mv);
    assign is_up = !is_set && (confirm_mv > cfg.up_lo_mv) && (confirm_mv < cfg.up_hi_mv);
    assign is_down = !is_set && !is_up &&
                     (confirm_mv > cfg.down_lo_mv) && (confirm_mv < cfg.down_hi_mv);

    // The left channel has its up and down buttons swapped.
    assign up_code = is_up ^ (channel == '0);
    assign elapsed = now_ms - state.start_ms;

    // Press, hold and release decisions for one poll.
    always_comb begin
        ev = EV_NONE;
        state_next = state;
        if (first_mv > cfg.release_mv) begin
            if (state.pressed) begin
                state_next.pressed = 1'b0;
                unique case (state.last_event)
                    EV_SET_PUSH, EV_LONG_SET: ev = EV_SET_REL;
                    EV_UP_PUSH: ev = EV_UP_REL;
                    EV_DOWN_PUSH: ev = EV_DOWN_REL;
                    default: ev = EV_NONE;
                endcase
            end
        end else if (confirm_mv <= cfg.release_mv) begin
            if (is_set || is_up || is_down) begin
                if (!state.pressed) begin
                    state_next.pressed = 1'b1;
                    state_next.start_ms = now_ms;
                end else if (is_set) begin
                    ev = (elapsed > TIME_W'(cfg.long_press_ms)) ? EV_LONG_SET : EV_SET_PUSH;
                end else if (elapsed > REPEAT_MS) begin
                    state_next.start_ms = now_ms;
                    ev = up_code ? EV_UP_PUSH : EV_DOWN_PUSH;
                end
            end
        end
        if (ev != EV_NONE) begin
            state_next.last_event = ev;
        end
    end

    assign event_code = ev;

endmodule

`default_nettype wire

// ===== hw/rtl/adc_ladder_keypad_decoder.sv =====
// An accepted request passes stage 1, stage 2 and the output register on its way to m_valid.
// Throughput: one request per cycle while no event waits on m_ready; a poll that causes
// no event leaves the pipe silently. The per-channel state memory has one read and one
// write port; a write-to-read bypass register covers polls of the same channel in
// consecutive cycles. Reset (aresetn low, synchronous) empties the pipe, restores the
// register defaults and marks every channel entry as not pressed with no previous event.
`timescale 1ns / 1ps
`default_nettype none

module adc_ladder_keypad_decoder
    import akd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire logic [CH_W-1:0]       s_channel,
    input  wire logic [SAMPLE_W-1:0]   s_first_sample,
    input  wire logic [SAMPLE_W-1:0]   s_confirm_sample,
    input  wire logic [TIME_W-1:0]     s_now_ms,
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic [CH_W-1:0]       m_event_channel,
    output      logic [2:0]            m_event_code,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg_reg;

    // Stage 1: scaled samples.
    logic                s1_valid_reg;
    logic [CH_W-1:0]     s1_channel_reg;
    logic [PROD_W-1:0]   s1_first_prod_reg;
    logic [PROD_W-1:0]   s1_confirm_prod_reg;
    logic [TIME_W-1:0]   s1_now_reg;

    // Stage 2: millivolts plus state read from memory.
    logic                s2_valid_reg;
    logic [CH_W-1:0]     s2_channel_reg;
    logic [MV_W-1:0]     s2_first_mv_reg;
    logic [MV_W-1:0]     s2_confirm_mv_reg;
    logic [TIME_W-1:0]   s2_now_reg;

    // Output register.
    logic                m_valid_reg;
    logic [CH_W-1:0]     m_channel_reg;
    event_code_t         m_code_reg;

    // Bypass of the most recent memory write and per-entry valid bits.
    logic                  byp_valid_reg;
    logic [CH_ADDR_W-1:0]  byp_addr_reg;
    chan_state_t           byp_data_reg;
    logic [CHANNELS-1:0]   ent_valid_reg;

    logic                  out_en;
    logic                  s2_has_ev;
    logic                  s2_go;
    logic                  s2_free;
    logic                  s1_free;
    logic                  s1_load;
    logic                  ram_re;
    logic                  ram_we;
    logic                  s2_ch_ok;
    logic [CH_ADDR_W-1:0]  s1_addr;
    logic [CH_ADDR_W-1:0]  s2_addr;
    logic [STATE_W-1:0]    ram_rdata;
    chan_state_t           s2_state;
    chan_state_t           s2_state_next;
    event_code_t           s2_event;

    // Handshake flow through the pipe; bubbles fill behind a waiting result.
    assign out_en = !m_valid_reg || m_ready;
    assign s2_has_ev = s2_ch_ok && (s2_event != EV_NONE);
    assign s2_go = s2_valid_reg && (!s2_has_ev || out_en);
    assign s2_free = !s2_valid_reg || s2_go;
    assign s1_free = !s1_valid_reg || s2_free;
    assign s1_load = s_valid && s1_free;
    assign s_ready = s1_free;

    assign s1_addr = CH_ADDR_W'(s1_channel_reg);
    assign s2_addr = CH_ADDR_W'(s2_channel_reg);
    assign s2_ch_ok = (32'(s2_channel_reg) < CHANNELS);
    assign ram_re = s1_valid_reg && s2_free;
    assign ram_we = s2_go && s2_ch_ok;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.release_mv <= RST_RELEASE_MV;
            cfg_reg.set_lo_mv <= RST_SET_LO_MV;
            cfg_reg.set_hi_mv <= RST_SET_HI_MV;
            cfg_reg.up_lo_mv <= RST_UP_LO_MV;
            cfg_reg.up_hi_mv <= RST_UP_HI_MV;
            cfg_reg.down_lo_mv <= RST_DOWN_LO_MV;
            cfg_reg.down_hi_mv <= RST_DOWN_HI_MV;
            cfg_reg.long_press_ms <= RST_LONG_PRESS_MS;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_RELEASE_MV: cfg_reg.release_mv <= cfg_wdata[MV_W-1:0];
                CFG_SET_LO_MV: cfg_reg.set_lo_mv <= cfg_wdata[MV_W-1:0];
                CFG_SET_HI_MV: cfg_reg.set_hi_mv <= cfg_wdata[MV_W-1:0];
                CFG_UP_LO_MV: cfg_reg.up_lo_mv <= cfg_wdata[MV_W-1:0];
                CFG_UP_HI_MV: cfg_reg.up_hi_mv <= cfg_wdata[MV_W-1:0];
                CFG_DOWN_LO_MV: cfg_reg.down_lo_mv <= cfg_wdata[MV_W-1:0];
                CFG_DOWN_HI_MV: cfg_reg.down_hi_mv <= cfg_wdata[MV_W-1:0];
                CFG_LONG_PRESS_MS: cfg_reg.long_press_ms <= cfg_wdata[LONG_W-1:0];
            endcase
        end
    end

    // Pipeline control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
            ent_valid_reg <= '0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en) begin
                m_valid_reg <= s2_valid_reg && s2_has_ev;
            end
            if (ram_we) begin
                byp_valid_reg <= 1'b1;
                ent_valid_reg[s2_addr] <= 1'b1;
            end
        end
    end

    // Stage 1 payload: multiply the raw samples by full-scale millivolts.
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_channel_reg <= s_channel;
            s1_first_prod_reg <= PROD_W'(s_first_sample) * PROD_W'(MV_FULL_SCALE);
            s1_confirm_prod_reg <= PROD_W'(s_confirm_sample) * PROD_W'(MV_FULL_SCALE);
            s1_now_reg <= s_now_ms;
        end
    end

    // Stage 2 payload: finish the conversion to millivolts.
    always_ff @(posedge aclk) begin
        if (ram_re) begin
            s2_channel_reg <= s1_channel_reg;
            s2_first_mv_reg <= mv_from_product(s1_first_prod_reg);
            s2_confirm_mv_reg <= mv_from_product(s1_confirm_prod_reg);
            s2_now_reg <= s1_now_reg;
        end
    end

    // Output payload and write bypass payload.
    always_ff @(posedge aclk) begin
        if (out_en && s2_valid_reg && s2_has_ev) begin
            m_channel_reg <= s2_channel_reg;
            m_code_reg <= s2_event;
        end
        if (ram_we) begin
            byp_addr_reg <= s2_addr;
            byp_data_reg <= s2_state_next;
        end
    end

    akd_ram #(
        .WIDTH(STATE_W),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .aclk(aclk),
        .we(ram_we),
        .waddr(s2_addr),
        .wdata(s2_state_next),
        .re(ram_re),
        .raddr(s1_addr),
        .rdata(ram_rdata)
    );

    // Resolve the channel state: the latest write wins, untouched entries read as reset.
    always_comb begin
        if (byp_valid_reg && (byp_addr_reg == s2_addr)) begin
            s2_state = byp_data_reg;
        end else if (!ent_valid_reg[s2_addr]) begin
            s2_state = STATE_RESET;
        end else begin
            s2_state = chan_state_t'(ram_rdata);
        end
    end

    akd_decide u_decide (
        .channel(s2_channel_reg),
        .first_mv(s2_first_mv_reg),
        .confirm_mv(s2_confirm_mv_reg),
        .now_ms(s2_now_reg),
        .cfg(cfg_reg),
        .state(s2_state),
        .event_code(s2_event),
        .state_next(s2_state_next)
    );

    assign m_valid = m_valid_reg;
    assign m_event_channel = m_channel_reg;
    assign m_event_code = m_code_reg;

    // A shown result never carries the no-event code.
    a_no_null_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_code_reg != EV_NONE))
        else $error("output shows the no-event code");

    // A new result only comes from a stage 2 poll that produced an event.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s2_valid_reg && s2_has_ev))
        else $error("result appeared without a decided event");

    // An empty front stage always takes a request.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_ready)
        else $error("front stage empty but not ready");

    // A poll held in stage 2 by a full output register does not write its state.
    a_no_write_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_has_ev && !out_en) |-> !ram_we)
        else $error("state written while the event is stalled");

endmodule

`default_nettype wire

// ===== tb/tb_adc_ladder_keypad_decoder.sv =====
`timescale 1ns / 1ps

module tb_adc_ladder_keypad_decoder;
    import akd_pkg::*;

    localparam int MAX_GAP = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int TARGET_POLLS = 430;

    // Buttons of the resistor ladder, used to pick a voltage window.
    typedef enum int {
        BTN_SET,
        BTN_UP,
        BTN_DOWN
    } button_t;

    typedef struct packed {
        logic        ch;
        event_code_t code;
    } key_event_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CH_W-1:0]       s_channel;
    logic [SAMPLE_W-1:0]   s_first_sample;
    logic [SAMPLE_W-1:0]   s_confirm_sample;
    logic [TIME_W-1:0]     s_now_ms;
    logic                  m_valid;
    logic                  m_ready;
    logic [CH_W-1:0]       m_event_channel;
    logic [2:0]            m_event_code;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Shadow of the register file and of the per-channel key state.
    cfg_t              keypad_cfg;
    logic              key_pressed [CHANNELS];
    logic [TIME_W-1:0] key_start_ms [CHANNELS];
    event_code_t       key_last [CHANNELS];

    key_event_t        pending_events [$];
    logic [TIME_W-1:0] now_tick;
    int                polls_sent;
    int                mismatches;
    bit                tx_idle;
    bit                rx_idle;
    int                rx_hold_cycles;

    adc_ladder_keypad_decoder u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_channel        (s_channel),
        .s_first_sample   (s_first_sample),
        .s_confirm_sample (s_confirm_sample),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_channel  (m_event_channel),
        .m_event_code     (m_event_code),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Convert a raw ADC code to millivolts, truncating.
    function automatic logic [MV_W-1:0] raw_to_mv(input logic [SAMPLE_W-1:0] raw);
        int unsigned prod;
        prod = int'(raw) * MV_FULL_SCALE;
        return MV_W'(prod / ADC_FULL_SCALE);
    endfunction

    // Smallest raw code that converts to the given millivolt value.
    function automatic logic [SAMPLE_W-1:0] raw_for_mv(input int mv);
        int raw;
        raw = (mv * ADC_FULL_SCALE + MV_FULL_SCALE - 1) / MV_FULL_SCALE;
        if (raw > ADC_FULL_SCALE) begin
            raw = ADC_FULL_SCALE;
        end
        return SAMPLE_W'(raw);
    endfunction

    function automatic logic in_window(input logic [MV_W-1:0] mv, input logic [MV_W-1:0] lo,
                                       input logic [MV_W-1:0] hi);
        return (mv > lo) && (mv < hi);
    endfunction

    // Decode one poll against the shadow state; EV_NONE means no event.
    function automatic event_code_t decode_poll(input logic ch,
                                                input logic [SAMPLE_W-1:0] first,
                                                input logic [SAMPLE_W-1:0] confirm,
                                                input logic [TIME_W-1:0] now);
        logic [MV_W-1:0]   mv_first;
        logic [MV_W-1:0]   mv_confirm;
        logic [TIME_W-1:0] held;
        logic              in_set;
        logic              in_up;
        logic              in_down;
        logic              up_code;
        event_code_t       code;
        code = EV_NONE;
        mv_first = raw_to_mv(first);
        mv_confirm = raw_to_mv(confirm);
        if (mv_first > keypad_cfg.release_mv) begin
            // Release: report the release that matches the last push.
            if (key_pressed[ch]) begin
                key_pressed[ch] = 1'b0;
                case (key_last[ch])
                    EV_SET_PUSH, EV_LONG_SET: code = EV_SET_REL;
                    EV_UP_PUSH: code = EV_UP_REL;
                    EV_DOWN_PUSH: code = EV_DOWN_REL;
                    default: code = EV_NONE;
                endcase
            end
        end else if (mv_confirm <= keypad_cfg.release_mv) begin
            in_set = in_window(mv_confirm, keypad_cfg.set_lo_mv, keypad_cfg.set_hi_mv);
            in_up = !in_set && in_window(mv_confirm, keypad_cfg.up_lo_mv, keypad_cfg.up_hi_mv);
            in_down = !in_set && !in_up &&
                      in_window(mv_confirm, keypad_cfg.down_lo_mv, keypad_cfg.down_hi_mv);
            if (in_set || in_up || in_down) begin
                if (!key_pressed[ch]) begin
                    key_pressed[ch] = 1'b1;
                    key_start_ms[ch] = now;
                end else begin
                    held = now - key_start_ms[ch];
                    if (in_set) begin
                        code = (held > {16'b0, keypad_cfg.long_press_ms}) ? EV_LONG_SET
                                                                          : EV_SET_PUSH;
                    end else if (held > REPEAT_MS) begin
                        // The left channel has up and down swapped.
                        up_code = (ch == 1'b0) ? !in_up : in_up;
                        key_start_ms[ch] = now;
                        code = up_code ? EV_UP_PUSH : EV_DOWN_PUSH;
                    end
                end
            end
        end
        if (code != EV_NONE) begin
            key_last[ch] = code;
        end
        return code;
    endfunction

    // Offer one poll request, wait for it to be taken, then record its event.
    task automatic send_poll(input logic ch, input logic [SAMPLE_W-1:0] first,
                             input logic [SAMPLE_W-1:0] confirm, input logic [TIME_W-1:0] now);
        int          gap;
        event_code_t code;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_channel <= ch;
        s_first_sample <= first;
        s_confirm_sample <= confirm;
        s_now_ms <= now;
        do @(posedge aclk); while (!s_ready);
        code = decode_poll(ch, first, confirm, now);
        if (code != EV_NONE) begin
            pending_events.push_back('{ch: ch, code: code});
        end
        polls_sent++;
    endtask

    // Stop offering requests and wait until every expected event has come out.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic program_register(input cfg_index_t idx, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RELEASE_MV: keypad_cfg.release_mv = data[MV_W-1:0];
            CFG_SET_LO_MV: keypad_cfg.set_lo_mv = data[MV_W-1:0];
            CFG_SET_HI_MV: keypad_cfg.set_hi_mv = data[MV_W-1:0];
            CFG_UP_LO_MV: keypad_cfg.up_lo_mv = data[MV_W-1:0];
            CFG_UP_HI_MV: keypad_cfg.up_hi_mv = data[MV_W-1:0];
            CFG_DOWN_LO_MV: keypad_cfg.down_lo_mv = data[MV_W-1:0];
            CFG_DOWN_HI_MV: keypad_cfg.down_hi_mv = data[MV_W-1:0];
            CFG_LONG_PRESS_MS: keypad_cfg.long_press_ms = data[LONG_W-1:0];
            default: ;
        endcase
    endtask

    // Write the whole register file; the pipe must be drained first.
    task automatic apply_settings(input int rel, input int set_lo, input int set_hi,
                                  input int up_lo, input int up_hi, input int down_lo,
                                  input int down_hi, input int long_ms);
        drain_pipeline();
        program_register(CFG_RELEASE_MV, rel);
        program_register(CFG_SET_LO_MV, set_lo);
        program_register(CFG_SET_HI_MV, set_hi);
        program_register(CFG_UP_LO_MV, up_lo);
        program_register(CFG_UP_HI_MV, up_hi);
        program_register(CFG_DOWN_LO_MV, down_lo);
        program_register(CFG_DOWN_HI_MV, down_hi);
        program_register(CFG_LONG_PRESS_MS, long_ms);
    endtask

    function automatic int mv_between(input int lo, input int hi);
        if (hi > lo + 1) begin
            return $urandom_range(lo + 1, hi - 1);
        end
        return $urandom_range(0, MV_FULL_SCALE);
    endfunction

    // Raw confirm reading that lands inside the chosen button's window.
    function automatic logic [SAMPLE_W-1:0] window_raw(input button_t button);
        case (button)
            BTN_SET: return raw_for_mv(mv_between(keypad_cfg.set_lo_mv, keypad_cfg.set_hi_mv));
            BTN_UP: return raw_for_mv(mv_between(keypad_cfg.up_lo_mv, keypad_cfg.up_hi_mv));
            default: return raw_for_mv(mv_between(keypad_cfg.down_lo_mv, keypad_cfg.down_hi_mv));
        endcase
    endfunction

    // First reading at or below the release threshold (key held).
    function automatic logic [SAMPLE_W-1:0] held_raw();
        return raw_for_mv($urandom_range(0, keypad_cfg.release_mv));
    endfunction

    // First reading above the release threshold, where one exists.
    function automatic logic [SAMPLE_W-1:0] release_raw();
        if (keypad_cfg.release_mv < MV_FULL_SCALE) begin
            return raw_for_mv($urandom_range(keypad_cfg.release_mv + 1, MV_FULL_SCALE));
        end
        return SAMPLE_W'($urandom_range(0, ADC_FULL_SCALE));
    endfunction

    // A plausible press: detection, a few held polls, maybe a window change, a release.
    task automatic press_sequence(input logic ch);
        button_t button;
        int      holds;
        button = button_t'($urandom_range(0, 2));
        holds = $urandom_range(1, 8);
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < holds; i++) begin
            if (i > 0 && $urandom_range(0, 5) == 0) begin
                button = button_t'($urandom_range(0, 2));
            end
            now_tick += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000)
                                                    : $urandom_range(0, 60);
            send_poll(ch, held_raw(), window_raw(button), now_tick);
        end
        now_tick += $urandom_range(0, 60);
        send_poll(ch, release_raw(), SAMPLE_W'($urandom_range(0, ADC_FULL_SCALE)), now_tick);
    endtask

    // Mostly press sequences, with random polls and time jumps mixed in.
    task automatic run_traffic(input int count);
        int stop_at;
        stop_at = polls_sent + count;
        while (polls_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                press_sequence(1'($urandom_range(0, 1)));
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    now_tick = $urandom;
                end else begin
                    now_tick += $urandom_range(0, 100);
                end
                send_poll(1'($urandom_range(0, 1)), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                          now_tick);
            end
        end
    endtask

    // Hand-picked polls against the reset register values.
    task automatic test_directed_cases();
        logic [SAMPLE_W-1:0] set_raw;
        logic [SAMPLE_W-1:0] up_raw;
        logic [SAMPLE_W-1:0] down_raw;
        logic [SAMPLE_W-1:0] gap_raw;
        set_raw = raw_for_mv(400);
        up_raw = raw_for_mv(1200);
        down_raw = raw_for_mv(2000);
        gap_raw = raw_for_mv(800);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // Release while not pressed, then set push, long set and set release.
        send_poll(1'b1, 12'hFFF, 12'h000, 32'd900);
        send_poll(1'b1, 12'h000, set_raw, 32'd1000);
        send_poll(1'b1, 12'h000, set_raw, 32'd1010);
        send_poll(1'b1, raw_for_mv(2800), set_raw, 32'd7000);
        send_poll(1'b1, 12'hFFF, set_raw, 32'd7010);
        send_poll(1'b1, 12'hFFF, 12'hFFF, 32'd7020);
        // Confirm reading above the threshold, outside every window, and at zero.
        send_poll(1'b1, 12'h000, 12'hFFF, 32'd7030);
        send_poll(1'b1, 12'h000, gap_raw, 32'd7040);
        send_poll(1'b1, 12'h000, 12'h000, 32'd7050);
        // Up repeat: exactly 40 ms gives nothing, 41 ms gives a push.
        send_poll(1'b1, 12'h000, up_raw, 32'd8000);
        send_poll(1'b1, 12'h000, up_raw, 32'd8040);
        send_poll(1'b1, 12'h000, up_raw, 32'd8041);
        send_poll(1'b1, 12'h000, up_raw, 32'd8082);
        send_poll(1'b1, 12'hFFF, 12'h000, 32'd8090);
        // Left channel: up and down swapped, timer wrap, window change mid press.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_poll(1'b0, 12'h000, up_raw, 32'hFFFF_FFF0);
        send_poll(1'b0, 12'h000, up_raw, 32'h0000_0020);
        send_poll(1'b0, 12'h000, down_raw, 32'h0000_0050);
        send_poll(1'b0, 12'hFFF, down_raw, 32'h0000_0060);
        // Release whose last event is already a release: nothing reported.
        send_poll(1'b0, 12'h000, set_raw, 32'h0000_0100);
        send_poll(1'b0, 12'hFFF, 12'hFFF, 32'h0000_0110);
        // Down on the right channel, then its release.
        send_poll(1'b1, 12'h000, down_raw, 32'h8000_0000);
        send_poll(1'b1, 12'h000, down_raw, 32'h8000_0030);
        send_poll(1'b1, 12'h000, down_raw, 32'h8000_0060);
        send_poll(1'b1, 12'hFFF, 12'hFFF, 32'h8000_0070);
        now_tick = 32'h8000_0100;
    endtask

    // Receiver holds off while set pushes keep coming, so the input stalls.
    task automatic test_output_backpressure();
        drain_pipeline();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 60; i++) begin
            now_tick += 41;
            send_poll(1'(i), 12'h000, window_raw(BTN_SET), now_tick);
        end
        // Pause until every event is out, then release both channels.
        drain_pipeline();
        send_poll(1'b0, 12'hFFF, 12'hFFF, now_tick);
        send_poll(1'b1, 12'hFFF, 12'hFFF, now_tick);
    endtask

    // Register extremes, overlapping windows and a return to the defaults.
    task automatic test_register_sweep();
        apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
        run_traffic(30);
        apply_settings(3300, 0, 3300, 0, 3300, 0, 3300, 65535);
        run_traffic(40);
        apply_settings(3000, 500, 1500, 1000, 2000, 1800, 2600, 0);
        run_traffic(40);
        apply_settings(2048, 2047, 2049, 1023, 1025, 4, 3299, 43690);
        run_traffic(30);
        apply_settings(RST_RELEASE_MV, RST_SET_LO_MV, RST_SET_HI_MV, RST_UP_LO_MV,
                       RST_UP_HI_MV, RST_DOWN_LO_MV, RST_DOWN_HI_MV, RST_LONG_PRESS_MS);
        run_traffic(40);
    endtask

    // Random ordered windows per phase until the poll budget is used up.
    task automatic test_random_settings();
        int lo [3];
        int hi [3];
        while (polls_sent < TARGET_POLLS) begin
            for (int b = 0; b < 3; b++) begin
                lo[b] = $urandom_range(0, 3000);
                hi[b] = lo[b] + $urandom_range(2, 800);
                if (hi[b] > MV_FULL_SCALE) begin
                    hi[b] = MV_FULL_SCALE;
                end
            end
            apply_settings($urandom_range(1500, 3300), lo[0], hi[0], lo[1], hi[1], lo[2], hi[2],
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 6000));
            run_traffic(40);
        end
    endtask

    // Accept each event request and compare it with the oldest expectation.
    initial begin : event_checker
        int         low;
        key_event_t want;
        m_ready = 1'b0;
        forever begin
            low = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold_cycles > 0) begin
                low = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (low > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (low - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_events.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected event, expected none, actual ch %0d code %0d",
                         $realtime, m_event_channel, m_event_code);
            end else begin
                want = pending_events.pop_front();
                if (m_event_channel !== want.ch) begin
                    mismatches++;
                    $display("%0t: event_channel mismatch, expected %0d, actual %0d",
                             $realtime, want.ch, m_event_channel);
                end
                if (m_event_code !== want.code) begin
                    mismatches++;
                    $display("%0t: event_code mismatch, expected %0d, actual %0d",
                             $realtime, want.code, m_event_code);
                end
            end
        end
    end

    initial begin : watchdog
        #400000;
        $display("tb_adc_ladder_keypad_decoder: FAIL");
        $finish;
    end

    initial begin : main_sequence
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_channel = '0;
        s_first_sample = '0;
        s_confirm_sample = '0;
        s_now_ms = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        mismatches = 0;
        polls_sent = 0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_cycles = 0;
        now_tick = $urandom;
        keypad_cfg = '{release_mv: RST_RELEASE_MV, set_lo_mv: RST_SET_LO_MV,
                       set_hi_mv: RST_SET_HI_MV, up_lo_mv: RST_UP_LO_MV,
                       up_hi_mv: RST_UP_HI_MV, down_lo_mv: RST_DOWN_LO_MV,
                       down_hi_mv: RST_DOWN_HI_MV, long_press_ms: RST_LONG_PRESS_MS};
        for (int i = 0; i < CHANNELS; i++) begin
            key_pressed[i] = 1'b0;
            key_start_ms[i] = '0;
            key_last[i] = EV_NONE;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_register_sweep();
        test_random_settings();

        drain_pipeline();
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("tb_adc_ladder_keypad_decoder: PASS");
        end else begin
            $display("tb_adc_ladder_keypad_decoder: FAIL");
        end
        $finish;
    end

endmodule
